// File: sv/tdtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TCP decision tree filter package
// Shared types and decision codes of the packet header classifier.
// ----------------------------------------------------------------------------
package tdtf_pkg;

   localparam int unsigned LEN_W   = 16;
   localparam int unsigned WORDS_W = 4;

   // Decision codes carried on the drop field.
   localparam logic DECISION_ACCEPT = 1'b0;
   localparam logic DECISION_DROP   = 1'b1;

   // Header fields of one request.
   typedef struct packed {
      logic               is_tcp;
      logic [LEN_W-1:0]   ip_total_length;
      logic [WORDS_W-1:0] ip_header_words;
      logic [LEN_W-1:0]   ip_ident;
      logic               dont_fragment;
      logic [WORDS_W-1:0] tcp_offset_words;
      logic               flag_fin;
      logic               flag_syn;
      logic               flag_ack;
      logic [LEN_W-1:0]   source_port;
      logic [LEN_W-1:0]   window_size;
   } header_type;

endpackage
`default_nettype wire

// File: sv/tdtf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TCP decision tree filter channels
// Valid/ready channels for header requests and drop decisions.
// ----------------------------------------------------------------------------
interface tdtf_req_if;
   logic                          valid;
   logic                          ready;
   logic                          is_tcp;
   logic [tdtf_pkg::LEN_W-1:0]    ip_total_length;
   logic [tdtf_pkg::WORDS_W-1:0]  ip_header_words;
   logic [tdtf_pkg::LEN_W-1:0]    ip_ident;
   logic                          dont_fragment;
   logic [tdtf_pkg::WORDS_W-1:0]  tcp_offset_words;
   logic                          flag_fin;
   logic                          flag_syn;
   logic                          flag_ack;
   logic [tdtf_pkg::LEN_W-1:0]    source_port;
   logic [tdtf_pkg::LEN_W-1:0]    window_size;

   modport source (
      output valid, is_tcp, ip_total_length, ip_header_words, ip_ident, dont_fragment,
             tcp_offset_words, flag_fin, flag_syn, flag_ack, source_port, window_size,
      input  ready
   );
   modport sink (
      input  valid, is_tcp, ip_total_length, ip_header_words, ip_ident, dont_fragment,
             tcp_offset_words, flag_fin, flag_syn, flag_ack, source_port, window_size,
      output ready
   );
endinterface

interface tdtf_rsp_if;
   logic valid;
   logic ready;
   logic drop;

   modport source (output valid, drop, input ready);
   modport sink (input valid, drop, output ready);
endinterface
`default_nettype wire

// File: sv/tdtf_classify.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TCP decision tree filter classifier
// Fixed tree of threshold compares on one registered header.
// ----------------------------------------------------------------------------
module tdtf_classify (
   input  wire tdtf_pkg::header_type hdr,
   output logic                      drop
);

   logic [tdtf_pkg::LEN_W-1:0] tl;
   logic [tdtf_pkg::LEN_W-1:0] id;
   logic [tdtf_pkg::LEN_W-1:0] sp;
   logic [tdtf_pkg::LEN_W-1:0] win;
   logic [tdtf_pkg::LEN_W-1:0] pay;
   logic [tdtf_pkg::WORDS_W+1:0] doff4;
   logic df;
   logic fin;
   logic syn;
   logic ack;

   assign tl    = hdr.ip_total_length;
   assign id    = hdr.ip_ident;
   assign sp    = hdr.source_port;
   assign win   = hdr.window_size;
   assign df    = hdr.dont_fragment;
   assign fin   = hdr.flag_fin;
   assign syn   = hdr.flag_syn;
   assign ack   = hdr.flag_ack;
   assign doff4 = {hdr.tcp_offset_words, 2'b00};

   // Payload length wraps modulo 2^16 when the headers claim more than the total.
   assign pay = tl - {{(tdtf_pkg::LEN_W-tdtf_pkg::WORDS_W-2){1'b0}}, hdr.ip_header_words, 2'b00}
                   - {{(tdtf_pkg::LEN_W-tdtf_pkg::WORDS_W-2){1'b0}}, doff4};

   always_comb begin
      drop = tdtf_pkg::DECISION_ACCEPT;
      if (!hdr.is_tcp) begin
         drop = tdtf_pkg::DECISION_ACCEPT;
      end else if (tl >= 16'd65) begin
         drop = tdtf_pkg::DECISION_ACCEPT;
      end else if (fin) begin
         if (win < 16'd512)          drop = tdtf_pkg::DECISION_ACCEPT;
         else if (!ack)              drop = tdtf_pkg::DECISION_DROP;
         else if (id < 16'd19)       drop = tdtf_pkg::DECISION_ACCEPT;
         else if (win >= 16'd16498)  drop = tdtf_pkg::DECISION_ACCEPT;
         else if (win < 16'd1024)    drop = tdtf_pkg::DECISION_ACCEPT;
         else if (sp < 16'd3152)     drop = tdtf_pkg::DECISION_ACCEPT;
         else if (sp < 16'd39166)    drop = tdtf_pkg::DECISION_DROP;
         else if (tl < 16'd58)       drop = tdtf_pkg::DECISION_ACCEPT;
         else                        drop = tdtf_pkg::DECISION_DROP;
      end else if (doff4 >= 6'd42) begin
         if (win < 16'd15749)        drop = tdtf_pkg::DECISION_ACCEPT;
         else if (win < 16'd23789)   drop = tdtf_pkg::DECISION_DROP;
         else                        drop = tdtf_pkg::DECISION_ACCEPT;
      end else if (sp < 16'd43521) begin
         if (win < 16'd1201) begin
            if (!df) begin
               if (!syn) begin
                  if (win < 16'd506)       drop = tdtf_pkg::DECISION_ACCEPT;
                  else if (sp < 16'd944)   drop = tdtf_pkg::DECISION_ACCEPT;
                  else                     drop = tdtf_pkg::DECISION_DROP;
               end else if (sp >= 16'd40073) begin
                  drop = tdtf_pkg::DECISION_ACCEPT;
               end else if (sp < 16'd3409) begin
                  drop = (win < 16'd768) ? tdtf_pkg::DECISION_DROP
                                         : tdtf_pkg::DECISION_ACCEPT;
               end else begin
                  drop = (sp < 16'd40058) ? tdtf_pkg::DECISION_ACCEPT
                                          : tdtf_pkg::DECISION_DROP;
               end
            end else if (id < 16'd33) begin
               if (sp < 16'd28708) begin
                  if (sp < 16'd2006)       drop = tdtf_pkg::DECISION_ACCEPT;
                  else if (sp < 16'd4166)  drop = tdtf_pkg::DECISION_DROP;
                  else                     drop = tdtf_pkg::DECISION_ACCEPT;
               end else begin
                  drop = (sp < 16'd33785) ? tdtf_pkg::DECISION_DROP
                                          : tdtf_pkg::DECISION_ACCEPT;
               end
            end else if (ack) begin
               drop = tdtf_pkg::DECISION_ACCEPT;
            end else if (sp >= 16'd23) begin
               drop = tdtf_pkg::DECISION_ACCEPT;
            end else begin
               drop = (id < 16'd47896) ? tdtf_pkg::DECISION_DROP
                                       : tdtf_pkg::DECISION_ACCEPT;
            end
         end else if (win < 16'd64240) begin
            if (pay < 16'd19) begin
               if (id < 16'd50800)       drop = tdtf_pkg::DECISION_ACCEPT;
               else if (id < 16'd50818)  drop = tdtf_pkg::DECISION_DROP;
               else                      drop = tdtf_pkg::DECISION_ACCEPT;
            end else begin
               drop = (sp < 16'd16552) ? tdtf_pkg::DECISION_ACCEPT
                                       : tdtf_pkg::DECISION_DROP;
            end
         end else if (sp < 16'd32746) begin
            drop = tdtf_pkg::DECISION_ACCEPT;
         end else if (win < 16'd64293) begin
            drop = (tl < 16'd56) ? tdtf_pkg::DECISION_ACCEPT : tdtf_pkg::DECISION_DROP;
         end else if (sp < 16'd33613) begin
            drop = (sp < 16'd33313) ? tdtf_pkg::DECISION_ACCEPT : tdtf_pkg::DECISION_DROP;
         end else begin
            drop = (sp < 16'd41889) ? tdtf_pkg::DECISION_ACCEPT : tdtf_pkg::DECISION_DROP;
         end
      end else if (sp < 16'd62217) begin
         if (win < 16'd64233) begin
            if (win < 16'd1) begin
               if (sp >= 16'd61992)      drop = tdtf_pkg::DECISION_DROP;
               else if (sp < 16'd55780)  drop = tdtf_pkg::DECISION_ACCEPT;
               else if (sp < 16'd55799)  drop = tdtf_pkg::DECISION_DROP;
               else                      drop = tdtf_pkg::DECISION_ACCEPT;
            end else if (pay < 16'd18) begin
               drop = tdtf_pkg::DECISION_ACCEPT;
            end else begin
               drop = (win < 16'd16528) ? tdtf_pkg::DECISION_ACCEPT
                                        : tdtf_pkg::DECISION_DROP;
            end
         end else if (tl < 16'd59) begin
            if (sp >= 16'd51418)      drop = tdtf_pkg::DECISION_ACCEPT;
            else if (sp < 16'd49003)  drop = tdtf_pkg::DECISION_ACCEPT;
            else if (id < 16'd54161)  drop = tdtf_pkg::DECISION_ACCEPT;
            else                      drop = tdtf_pkg::DECISION_DROP;
         end else begin
            drop = (win < 16'd64520) ? tdtf_pkg::DECISION_DROP : tdtf_pkg::DECISION_ACCEPT;
         end
      end else if (win < 16'd1025) begin
         if (!df) begin
            if (sp < 16'd62237)       drop = tdtf_pkg::DECISION_DROP;
            else if (!ack)            drop = tdtf_pkg::DECISION_ACCEPT;
            else if (win < 16'd769)   drop = tdtf_pkg::DECISION_ACCEPT;
            else                      drop = tdtf_pkg::DECISION_DROP;
         end else if (ack) begin
            drop = tdtf_pkg::DECISION_ACCEPT;
         end else begin
            drop = (sp < 16'd62330) ? tdtf_pkg::DECISION_DROP : tdtf_pkg::DECISION_ACCEPT;
         end
      end else if (pay < 16'd18) begin
         if (id < 16'd46559)       drop = tdtf_pkg::DECISION_ACCEPT;
         else if (id < 16'd46771)  drop = tdtf_pkg::DECISION_DROP;
         else                      drop = tdtf_pkg::DECISION_ACCEPT;
      end else begin
         drop = tdtf_pkg::DECISION_DROP;
      end
   end

endmodule
`default_nettype wire

// File: sv/tcp_decision_tree_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TCP decision tree filter
// Classifies each TCP/IPv4 header request as accept or drop.
// Each accepted request passes the input register, the tree and the result
//   register in that order; a stall on the result side holds it in place.
// Throughput: one request per cycle while the result side keeps taking results.
// Reset clears both valid flags; the header and result registers are not reset.
// ----------------------------------------------------------------------------
module tcp_decision_tree_filter (
   input  wire         clock,
   input  wire         reset,
   tdtf_req_if.sink    req_chan,
   tdtf_rsp_if.source  rsp_chan
);

   tdtf_pkg::header_type hdr_ff;
   tdtf_pkg::header_type hdr_in;
   logic                 hdr_valid_ff;
   logic                 rsp_valid_ff;
   logic                 drop_ff;
   logic                 drop_in;
   logic                 rsp_open;
   logic                 hdr_open;

   // Each stage moves whenever the stage after it is empty or draining.
   assign rsp_open       = !rsp_valid_ff || rsp_chan.ready;
   assign hdr_open       = !hdr_valid_ff || rsp_open;
   assign req_chan.ready = hdr_open;

   assign hdr_in = '{
      is_tcp:           req_chan.is_tcp,
      ip_total_length:  req_chan.ip_total_length,
      ip_header_words:  req_chan.ip_header_words,
      ip_ident:         req_chan.ip_ident,
      dont_fragment:    req_chan.dont_fragment,
      tcp_offset_words: req_chan.tcp_offset_words,
      flag_fin:         req_chan.flag_fin,
      flag_syn:         req_chan.flag_syn,
      flag_ack:         req_chan.flag_ack,
      source_port:      req_chan.source_port,
      window_size:      req_chan.window_size
   };

   tdtf_classify u_classify (
      .hdr  (hdr_ff),
      .drop (drop_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (hdr_open) begin
            hdr_valid_ff <= req_chan.valid;
         end
         if (rsp_open) begin
            rsp_valid_ff <= hdr_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_open && req_chan.valid) begin
         hdr_ff <= hdr_in;
      end
      if (rsp_open && hdr_valid_ff) begin
         drop_ff <= drop_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.drop  = drop_ff;

endmodule
`default_nettype wire
